// ===== rtl/core/tsbb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsbb_pkg: texture slot batch binner shared types and constants
// Register codes, field widths and the cell control word.
// ----------------------------------------------------------------------------
package tsbb_pkg;

   localparam int QUAD_CAP    = 16384;
   localparam int QUAD_W      = 15;
   localparam int SLIM_W      = 6;
   localparam int LIM_CMP_W   = 7;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_IDX_W   = 1;
   localparam int ENT_W       = 32;
   localparam int SLOT_OUT_W  = 5;
   localparam int IDX_OUT_W   = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_QUAD_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT = 1'd1;

   localparam logic FUNC_SUBMIT = 1'b0;
   localparam logic FUNC_CLOSE  = 1'b1;

   typedef struct packed {
      logic search;   // capture a compare against the incoming id
      logic load;     // write the committed id into the addressed cell
   } cell_ctl_type;

endpackage

// ===== rtl/core/tsbb_req_if.sv =====
// ----------------------------------------------------------------------------
// tsbb_req_if: request channel
// Valid/ready channel carrying one submitted quad or end-batch command.
// ----------------------------------------------------------------------------
interface tsbb_req_if #(
   parameter int ID_BITS = 16
);
   logic                valid;
   logic                ready;
   logic                func;
   logic [ID_BITS-1:0]  texture_id;
   logic signed [31:0]  entity_id;

   modport source (output valid, output func, output texture_id, output entity_id,
                   input ready);
   modport sink   (input valid, input func, input texture_id, input entity_id,
                   output ready);
endinterface

// ===== rtl/core/tsbb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tsbb_rsp_if: response channel
// Valid/ready channel carrying the slot assignment for one request word.
// ----------------------------------------------------------------------------
interface tsbb_rsp_if;
   logic                valid;
   logic                ready;
   logic                batch_closed;
   logic [14:0]         closed_quads;
   logic [4:0]          slot;
   logic [13:0]         instance_index;
   logic signed [31:0]  entity_echo;

   modport source (output valid, output batch_closed, output closed_quads, output slot,
                   output instance_index, output entity_echo, input ready);
   modport sink   (input valid, input batch_closed, input closed_quads, input slot,
                   input instance_index, input entity_echo, output ready);
endinterface

// ===== rtl/core/texture_slot_batch_binner_top.sv =====
// A request word is accepted, then its result is registered in the commit cycle;
// no new word is taken before that commit. The cell row compares in the accept
// cycle and the slot and batch counters update in the commit cycle.
// A result waiting on the response channel holds the commit cycle back.
// Reset: synchronous; batch empty, slot 0 only in use, limits at 16384 and 32.
// Slot ids are not cleared; slots beyond the in-use count are never matched.
// ----------------------------------------------------------------------------
// texture_slot_batch_binner_top: texture slot batching
// Assigns texture slots and instance indices to quads and closes batches on
// quad limit, slot exhaustion or an explicit end-batch word.
// ----------------------------------------------------------------------------
module texture_slot_batch_binner_top
   import tsbb_pkg::*;
#(
   parameter int SLOTS   = 32,
   parameter int ID_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   tsbb_req_if.sink               req_ch,
   tsbb_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int USED_W = $clog2(SLOTS+1);
   localparam logic [USED_W-1:0]    USED_ONE = USED_W'(1);
   localparam logic [QUAD_W-1:0]    QMAX     = QUAD_W'(QUAD_CAP);
   localparam logic [LIM_CMP_W-1:0] SMAX     = LIM_CMP_W'(SLOTS);
   localparam logic [LIM_CMP_W-1:0] SMIN     = LIM_CMP_W'(2);

   // configuration
   logic [QUAD_W-1:0] quad_limit_ff;
   logic [SLIM_W-1:0] slot_limit_ff;
   logic [QUAD_W-1:0] qlim;
   logic [LIM_CMP_W-1:0] slim;

   // batch state
   logic [USED_W-1:0] used_ff,  used_in;
   logic [QUAD_W-1:0] quads_ff, quads_in;
   logic              busy_ff,  busy_in;

   // request held for the commit cycle
   logic               func_ff;
   logic [ID_BITS-1:0] tex_ff;
   logic signed [31:0] ent_ff;
   logic               qclose_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               closed_ff;
   logic [QUAD_W-1:0]  closed_n_ff;
   logic [SLOT_OUT_W-1:0] slot_ff;
   logic [IDX_OUT_W-1:0]  idx_ff;
   logic signed [31:0] echo_ff;

   logic accept, commit, qclose_now;
   logic [USED_W-1:0] used_lim;
   cell_ctl_type ctl;
   logic found;
   logic [SLOT_W-1:0] found_slot;

   // commit values
   logic              c_closed;
   logic [QUAD_W-1:0] c_closed_n;
   logic [SLOT_W-1:0] c_slot;
   logic [QUAD_W-1:0] c_idx;
   logic              c_bind;

   always_comb begin
      qlim = quad_limit_ff;
      if (qlim == '0) qlim = QUAD_W'(1);
      if (qlim > QMAX) qlim = QMAX;
      slim = LIM_CMP_W'(slot_limit_ff);
      if (slim < SMIN) slim = SMIN;
      if (slim > SMAX) slim = SMAX;
   end

   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && !busy_ff;
   assign commit       = busy_ff && (!rsp_valid_ff || rsp_ch.ready);

   // a quad-limit close empties the slot table before the search
   assign qclose_now = (quads_ff >= qlim);
   assign used_lim   = qclose_now ? USED_ONE : used_ff;

   assign ctl.search = accept;
   assign ctl.load   = commit && c_bind;

   tsbb_slot_chain #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .query_id   (req_ch.texture_id),
      .used_lim   (used_lim),
      .wr_slot    (c_slot),
      .wr_id      (tex_ff),
      .found      (found),
      .found_slot (found_slot)
   );

   always_comb begin
      logic [USED_W-1:0] used_a;
      logic [QUAD_W-1:0] quads_a;
      used_a     = qclose_ff ? USED_ONE : used_ff;
      quads_a    = qclose_ff ? '0 : quads_ff;
      c_closed   = qclose_ff;
      c_closed_n = qclose_ff ? quads_ff : '0;
      c_slot     = '0;
      c_bind     = 1'b0;
      c_idx      = '0;
      used_in    = used_ff;
      quads_in   = quads_ff;
      if (func_ff == FUNC_CLOSE) begin
         c_closed   = 1'b1;
         c_closed_n = quads_ff;
         used_in    = USED_ONE;
         quads_in   = '0;
      end else begin
         if (tex_ff != '0) begin
            if (found) begin
               c_slot = found_slot;
            end else begin
               // new texture with the slot limit reached: close, then bind slot 1
               if (LIM_CMP_W'(used_a) >= slim) begin
                  c_closed   = 1'b1;
                  c_closed_n = quads_a;
                  used_a     = USED_ONE;
                  quads_a    = '0;
               end
               c_slot = used_a[SLOT_W-1:0];
               c_bind = 1'b1;
               used_a = used_a + USED_ONE;
            end
         end
         c_idx    = quads_a;
         used_in  = used_a;
         quads_in = quads_a + QUAD_W'(1);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if (commit) busy_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (commit) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_limit_ff <= QMAX;
         slot_limit_ff <= SLIM_W'(32);
         used_ff       <= USED_ONE;
         quads_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            used_ff  <= used_in;
            quads_ff <= quads_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_QUAD_LIMIT: quad_limit_ff <= csr_wdata;
               CSR_SLOT_LIMIT: slot_limit_ff <= csr_wdata[SLIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_ch.func;
         tex_ff    <= req_ch.texture_id;
         ent_ff    <= req_ch.entity_id;
         qclose_ff <= qclose_now;
      end
      if (commit) begin
         logic [LIM_CMP_W-1:0] slot_wide;
         slot_wide   = LIM_CMP_W'(c_slot);
         closed_ff   <= c_closed;
         closed_n_ff <= c_closed_n;
         slot_ff     <= slot_wide[SLOT_OUT_W-1:0];
         idx_ff      <= c_idx[IDX_OUT_W-1:0];
         echo_ff     <= (func_ff == FUNC_CLOSE) ? 32'sd0 : ent_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.batch_closed   = closed_ff;
   assign rsp_ch.closed_quads   = closed_n_ff;
   assign rsp_ch.slot           = slot_ff;
   assign rsp_ch.instance_index = idx_ff;
   assign rsp_ch.entity_echo    = echo_ff;

   // one word in flight: nothing accepted in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("request taken while a word is in flight");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      (used_ff != '0) && (LIM_CMP_W'(used_ff) <= SMAX))
      else $error("slot use count out of range");

   a_quads_range: assert property (@(posedge clock) disable iff (reset)
      quads_ff <= QMAX)
      else $error("quad count above maximum");

   a_white_slot: assert property (@(posedge clock) disable iff (reset)
      (commit && (tex_ff == '0)) |=> (rsp_ch.slot == '0))
      else $error("white texture given a nonzero slot");

endmodule

// ===== rtl/core/tsbb_slot_cell.sv =====
// ----------------------------------------------------------------------------
// tsbb_slot_cell: one texture slot
// Holds the id bound to its slot, registers a match against the query and
// folds its match into the found/slot word passed on to the next cell.
// ----------------------------------------------------------------------------
module tsbb_slot_cell
   import tsbb_pkg::*;
#(
   parameter int SLOTS   = 32,
   parameter int ID_BITS = 16,
   parameter int INDEX   = 1
) (
   input  logic                         clock,
   input  cell_ctl_type                 ctl,
   input  logic [ID_BITS-1:0]           query_id,
   input  logic [$clog2(SLOTS+1)-1:0]   used_lim,
   input  logic [$clog2(SLOTS)-1:0]     wr_slot,
   input  logic [ID_BITS-1:0]           wr_id,
   input  logic                         found_in,
   input  logic [$clog2(SLOTS)-1:0]     slot_in,
   output logic                         found_out,
   output logic [$clog2(SLOTS)-1:0]     slot_out
);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int USED_W = $clog2(SLOTS+1);
   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

   logic [ID_BITS-1:0] id_ff;
   logic               hit_ff;
   logic               hit_in;

   // only slots bound in the current batch take part in the search
   assign hit_in = (USED_W'(INDEX) < used_lim) && (id_ff == query_id);

   always_ff @(posedge clock) begin
      if (ctl.search) begin
         hit_ff <= hit_in;
      end
      if (ctl.load && (wr_slot == MY_SLOT)) begin
         id_ff <= wr_id;
      end
   end

   assign found_out = found_in | hit_ff;
   assign slot_out  = hit_ff ? MY_SLOT : slot_in;

endmodule

// ===== rtl/core/tsbb_slot_chain.sv =====
// ----------------------------------------------------------------------------
// tsbb_slot_chain: row of slot cells
// Cells 1..SLOTS-1; slot 0 is the white texture and has no cell.
// ----------------------------------------------------------------------------
module tsbb_slot_chain
   import tsbb_pkg::*;
#(
   parameter int SLOTS   = 32,
   parameter int ID_BITS = 16
) (
   input  logic                         clock,
   input  cell_ctl_type                 ctl,
   input  logic [ID_BITS-1:0]           query_id,
   input  logic [$clog2(SLOTS+1)-1:0]   used_lim,
   input  logic [$clog2(SLOTS)-1:0]     wr_slot,
   input  logic [ID_BITS-1:0]           wr_id,
   output logic                         found,
   output logic [$clog2(SLOTS)-1:0]     found_slot
);
   localparam int SLOT_W = $clog2(SLOTS);

   logic              found_w [SLOTS];
   logic [SLOT_W-1:0] slot_w  [SLOTS];

   assign found_w[0] = 1'b0;
   assign slot_w[0]  = '0;

   for (genvar i = 1; i < SLOTS; i++) begin : g_cell
      tsbb_slot_cell #(
         .SLOTS   (SLOTS),
         .ID_BITS (ID_BITS),
         .INDEX   (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .query_id  (query_id),
         .used_lim  (used_lim),
         .wr_slot   (wr_slot),
         .wr_id     (wr_id),
         .found_in  (found_w[i-1]),
         .slot_in   (slot_w[i-1]),
         .found_out (found_w[i]),
         .slot_out  (slot_w[i])
      );
   end

   assign found      = found_w[SLOTS-1];
   assign found_slot = slot_w[SLOTS-1];

endmodule
